[rtl/core/hsl2rgb_pkg.sv]
package hsl2rgb_pkg;

    localparam int FRAC_BITS = 15;
    localparam int VAL_W     = 16;
    localparam int ONE_I     = 1 << FRAC_BITS;

    // thresholds rounded to nearest
    localparam logic [VAL_W-1:0] ONE        = VAL_W'(ONE_I);
    localparam logic [VAL_W-1:0] THIRD      = VAL_W'((ONE_I + 1) / 3);
    localparam logic [VAL_W-1:0] SIXTH      = VAL_W'((ONE_I + 3) / 6);
    localparam logic [VAL_W-1:0] HALF       = VAL_W'(ONE_I / 2);
    localparam logic [VAL_W-1:0] TWO_THIRDS = VAL_W'((2 * ONE_I + 1) / 3);

    // ramp operand widths: d*6 needs three more bits than d
    localparam int OPA_W  = VAL_W + 3;
    localparam int PROD_W = OPA_W + VAL_W;

    typedef enum logic [1:0] {
        RGN_RISE,
        RGN_TOP,
        RGN_FALL,
        RGN_BASE
    } region_t;

    typedef struct packed {
        logic load3;
        logic load4;
    } pipe_ctl_t;

    function automatic logic [VAL_W-1:0] sat_one(input logic [VAL_W-1:0] v);
        sat_one = (v > ONE) ? ONE : v;
    endfunction

endpackage

[rtl/core/hsl2rgb_channel.sv]
module hsl2rgb_channel (
    input  logic                            clk,
    input  hsl2rgb_pkg::pipe_ctl_t          ctl,
    input  logic [hsl2rgb_pkg::VAL_W-1:0]   t,
    input  logic [hsl2rgb_pkg::VAL_W-1:0]   p,
    input  logic [hsl2rgb_pkg::VAL_W-1:0]   q,
    input  logic [hsl2rgb_pkg::VAL_W-1:0]   d,
    output logic [hsl2rgb_pkg::VAL_W-1:0]   value
);

    hsl2rgb_pkg::region_t               region3_reg;
    hsl2rgb_pkg::region_t               region3_next;
    logic [hsl2rgb_pkg::VAL_W-1:0]      opb3_reg;
    logic [hsl2rgb_pkg::VAL_W-1:0]      opb3_next;
    logic [hsl2rgb_pkg::OPA_W-1:0]      fall6;

    hsl2rgb_pkg::region_t               region4_reg;
    logic [hsl2rgb_pkg::VAL_W-1:0]      prod4_reg;
    logic [hsl2rgb_pkg::VAL_W-1:0]      prod4_next;
    logic [hsl2rgb_pkg::VAL_W-1:0]      p4_reg;
    logic [hsl2rgb_pkg::VAL_W-1:0]      q4_reg;

    logic [hsl2rgb_pkg::OPA_W-1:0]      opa;
    logic [hsl2rgb_pkg::PROD_W-1:0]     prod_full;
    logic [hsl2rgb_pkg::VAL_W:0]        sum;

    // region of the hue ramp and the second multiplier operand
    always_comb
    begin
        fall6 = (hsl2rgb_pkg::OPA_W'(hsl2rgb_pkg::TWO_THIRDS - t) << 2)
              + (hsl2rgb_pkg::OPA_W'(hsl2rgb_pkg::TWO_THIRDS - t) << 1);
        if (t < hsl2rgb_pkg::SIXTH)
        begin
            region3_next = hsl2rgb_pkg::RGN_RISE;
            opb3_next    = t;
        end
        else if (t < hsl2rgb_pkg::HALF)
        begin
            region3_next = hsl2rgb_pkg::RGN_TOP;
            opb3_next    = '0;
        end
        else if (t < hsl2rgb_pkg::TWO_THIRDS)
        begin
            region3_next = hsl2rgb_pkg::RGN_FALL;
            opb3_next    = fall6[hsl2rgb_pkg::VAL_W-1:0];
        end
        else
        begin
            region3_next = hsl2rgb_pkg::RGN_BASE;
            opb3_next    = '0;
        end
    end

    // rising edge scales d by six, falling edge scales the distance by six
    always_comb
    begin
        if (region3_reg == hsl2rgb_pkg::RGN_RISE)
        begin
            opa = (hsl2rgb_pkg::OPA_W'(d) << 2) + (hsl2rgb_pkg::OPA_W'(d) << 1);
        end
        else
        begin
            opa = hsl2rgb_pkg::OPA_W'(d);
        end
        prod_full  = hsl2rgb_pkg::PROD_W'(opa) * hsl2rgb_pkg::PROD_W'(opb3_reg);
        prod4_next = prod_full[hsl2rgb_pkg::FRAC_BITS +: hsl2rgb_pkg::VAL_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load3)
        begin
            region3_reg <= region3_next;
            opb3_reg    <= opb3_next;
        end
        if (ctl.load4)
        begin
            region4_reg <= region3_reg;
            prod4_reg   <= prod4_next;
            p4_reg      <= p;
            q4_reg      <= q;
        end
    end

    always_comb
    begin
        sum = {1'b0, p4_reg} + {1'b0, prod4_reg};
        case (region4_reg)
            hsl2rgb_pkg::RGN_RISE,
            hsl2rgb_pkg::RGN_FALL:
            begin
                if (sum > {1'b0, hsl2rgb_pkg::ONE})
                begin
                    value = hsl2rgb_pkg::ONE;
                end
                else
                begin
                    value = sum[hsl2rgb_pkg::VAL_W-1:0];
                end
            end
            hsl2rgb_pkg::RGN_TOP:  value = q4_reg;
            hsl2rgb_pkg::RGN_BASE: value = p4_reg;
            default:               value = p4_reg;
        endcase
    end

endmodule

[rtl/core/hsl_to_rgb_converter.sv]
// hsl to rgb pixel converter
//
// slave side: one pixel per word, tdata = {lightness, saturation, hue},
// each a 16-bit fraction where 32768 is 1.0; larger codes read as 1.0.
// master side: one word per pixel, tdata = {blue, green, red}, same format.
//
// five register stages: saturate, l*s product and hue offsets, q/p/d with
// ramp region, one ramp multiplier per channel, clamp into the output
// register. a word taken into the saturate stage goes on through the product,
// q/p/d and multiplier registers to the output; one pixel per cycle while
// the receiver is ready; the second and fourth stage multipliers are combinational.
//
// reset clears the stage valid bits only; the pipeline starts empty.
// each stage moves when the one after it is empty or moving, so a stalled
// receiver holds the output word and the stages behind it fill up; s_axis
// tready drops only once all five stages hold a pixel.
module hsl_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // hue[15:0], saturation[31:16], lightness[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // red[15:0], green[31:16], blue[47:32]
);

    localparam int W     = hsl2rgb_pkg::VAL_W;
    localparam int NSTG  = 5;

    logic [NSTG-1:0]     vld_reg;
    logic [NSTG-1:0]     vld_next;
    logic [NSTG-1:0]     adv;

    // stage 1
    logic [W-1:0]        h1_reg, s1_reg, l1_reg;
    // stage 2
    logic [2*W-1:0]      ls2_reg;
    logic [2*W-1:0]      ls2_next;
    logic [W-1:0]        s2_reg, l2_reg;
    logic [W-1:0]        tr2_reg, tg2_reg, tb2_reg;
    logic [W-1:0]        tr2_next, tb2_next;
    logic                flat2_reg;
    logic [W:0]          hr_sum;
    // stage 3
    logic [W-1:0]        q3_reg, p3_reg, d3_reg, l3_reg;
    logic [W-1:0]        q3_next, p3_next, d3_next;
    logic                flat3_reg;
    logic [W-1:0]        ls;
    logic [W:0]          q_wide, p_wide, d_wide;
    // stage 4
    logic [W-1:0]        l4_reg;
    logic                flat4_reg;
    // output
    logic [3*W-1:0]      out_reg;
    logic [3*W-1:0]      out_next;

    logic [W-1:0]        red_val, green_val, blue_val;
    hsl2rgb_pkg::pipe_ctl_t ctl;

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? s_axis_tvalid : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = out_reg;

    // l*s product, and hue offsets by a third, wrapped once into 0..1
    always_comb
    begin
        ls2_next = (2*W)'(l1_reg) * (2*W)'(s1_reg);
        hr_sum   = {1'b0, h1_reg} + {1'b0, hsl2rgb_pkg::THIRD};
        if (hr_sum > {1'b0, hsl2rgb_pkg::ONE})
        begin
            tr2_next = W'(hr_sum - {1'b0, hsl2rgb_pkg::ONE});
        end
        else
        begin
            tr2_next = hr_sum[W-1:0];
        end
        if (h1_reg < hsl2rgb_pkg::THIRD)
        begin
            tb2_next = h1_reg + hsl2rgb_pkg::ONE - hsl2rgb_pkg::THIRD;
        end
        else
        begin
            tb2_next = h1_reg - hsl2rgb_pkg::THIRD;
        end
    end

    // q, p and d = q - p formed side by side from l, s and l*s
    always_comb
    begin
        ls = ls2_reg[hsl2rgb_pkg::FRAC_BITS +: W];
        if (l2_reg < hsl2rgb_pkg::HALF)
        begin
            q_wide = {1'b0, l2_reg} + {1'b0, ls};
            p_wide = {1'b0, l2_reg} - {1'b0, ls};
            d_wide = {ls, 1'b0};
        end
        else
        begin
            q_wide = {1'b0, l2_reg} + {1'b0, s2_reg} - {1'b0, ls};
            p_wide = {1'b0, l2_reg} + {1'b0, ls} - {1'b0, s2_reg};
            d_wide = {(s2_reg - ls), 1'b0};
        end
        q3_next = q_wide[W-1:0];
        p3_next = p_wide[W-1:0];
        d3_next = d_wide[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            h1_reg <= hsl2rgb_pkg::sat_one(s_axis_tdata[W-1:0]);
            s1_reg <= hsl2rgb_pkg::sat_one(s_axis_tdata[2*W-1:W]);
            l1_reg <= hsl2rgb_pkg::sat_one(s_axis_tdata[3*W-1:2*W]);
        end
        if (adv[1])
        begin
            ls2_reg   <= ls2_next;
            s2_reg    <= s1_reg;
            l2_reg    <= l1_reg;
            tr2_reg   <= tr2_next;
            tg2_reg   <= h1_reg;
            tb2_reg   <= tb2_next;
            flat2_reg <= (s1_reg == '0);
        end
        if (adv[2])
        begin
            q3_reg    <= q3_next;
            p3_reg    <= p3_next;
            d3_reg    <= d3_next;
            l3_reg    <= l2_reg;
            flat3_reg <= flat2_reg;
        end
        if (adv[3])
        begin
            l4_reg    <= l3_reg;
            flat4_reg <= flat3_reg;
        end
        if (adv[4])
        begin
            out_reg <= out_next;
        end
    end

    assign ctl.load3 = adv[2];
    assign ctl.load4 = adv[3];

    hsl2rgb_channel u_red (
        .clk   (clk),
        .ctl   (ctl),
        .t     (tr2_reg),
        .p     (p3_reg),
        .q     (q3_reg),
        .d     (d3_reg),
        .value (red_val)
    );

    hsl2rgb_channel u_green (
        .clk   (clk),
        .ctl   (ctl),
        .t     (tg2_reg),
        .p     (p3_reg),
        .q     (q3_reg),
        .d     (d3_reg),
        .value (green_val)
    );

    hsl2rgb_channel u_blue (
        .clk   (clk),
        .ctl   (ctl),
        .t     (tb2_reg),
        .p     (p3_reg),
        .q     (q3_reg),
        .d     (d3_reg),
        .value (blue_val)
    );

    // grey pixel when saturation is zero
    always_comb
    begin
        if (flat4_reg)
        begin
            out_next = {l4_reg, l4_reg, l4_reg};
        end
        else
        begin
            out_next = {blue_val, green_val, red_val};
        end
    end

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[W-1:0] <= hsl2rgb_pkg::ONE)
            && (m_axis_tdata[2*W-1:W] <= hsl2rgb_pkg::ONE)
            && (m_axis_tdata[3*W-1:2*W] <= hsl2rgb_pkg::ONE))
        else $error("output channel above one");

    a_qpd: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (q3_reg >= p3_reg) && (d3_reg == W'(q3_reg - p3_reg))
            && (q3_reg <= hsl2rgb_pkg::ONE))
        else $error("q, p and d inconsistent");

    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && adv[1] |=> vld_reg[1])
        else $error("pixel lost between first and second stage");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg) && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

[tb/tb_hsl_to_rgb_converter.sv]
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter;

    typedef struct packed {
        logic [15:0] lightness;
        logic [15:0] saturation;
        logic [15:0] hue;
    } hsl_t;

    typedef struct packed {
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } rgb_t;

    localparam longint UNIT_L       = longint'(hsl2rgb_pkg::ONE);
    localparam longint THIRD_L      = longint'(hsl2rgb_pkg::THIRD);
    localparam longint SIXTH_L      = longint'(hsl2rgb_pkg::SIXTH);
    localparam longint HALF_L       = longint'(hsl2rgb_pkg::HALF);
    localparam longint TWO_THIRDS_L = longint'(hsl2rgb_pkg::TWO_THIRDS);
    localparam int     RANDOM_PIXELS = 1450;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;

    hsl_t hsl_pending[$];
    rgb_t rgb_expected[int];

    int n_pixels;
    int n_launched;
    int n_accepted;
    int n_checked;
    int err_count;
    int drain_at_a;
    int drain_at_b;

    hsl_to_rgb_converter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    function automatic longint clamp_unit(longint v);
        if (v < 0)
            return 0;
        if (v > UNIT_L)
            return UNIT_L;
        return v;
    endfunction

    // piecewise hue ramp between p and q
    function automatic longint ramp_level(longint p, longint q, longint t);
        longint d;
        d = q - p;
        if (d < 0)
            d = 0;
        if (t < 0)
            t = t + UNIT_L;
        if (t > UNIT_L)
            t = t - UNIT_L;
        if (t < SIXTH_L)
        begin
            if (t < 0)
                t = 0;
            return clamp_unit(p + ((d * 6 * t) >> hsl2rgb_pkg::FRAC_BITS));
        end
        if (t < HALF_L)
            return clamp_unit(q);
        if (t < TWO_THIRDS_L)
            return clamp_unit(p + ((d * ((TWO_THIRDS_L - t) * 6)) >> hsl2rgb_pkg::FRAC_BITS));
        return clamp_unit(p);
    endfunction

    function automatic rgb_t predict_rgb(hsl_t px);
        longint h;
        longint s;
        longint l;
        longint ls;
        longint q;
        longint p;
        rgb_t   c;
        h = (px.hue > hsl2rgb_pkg::ONE) ? UNIT_L : longint'(px.hue);
        s = (px.saturation > hsl2rgb_pkg::ONE) ? UNIT_L : longint'(px.saturation);
        l = (px.lightness > hsl2rgb_pkg::ONE) ? UNIT_L : longint'(px.lightness);
        if (s == 0)
        begin
            c.red   = 16'(l);
            c.green = 16'(l);
            c.blue  = 16'(l);
        end
        else
        begin
            ls = (l * s) >> hsl2rgb_pkg::FRAC_BITS;
            q  = (l < HALF_L) ? (l + ls) : (l + s - ls);
            p  = 2 * l - q;
            c.red   = 16'(ramp_level(p, q, h + THIRD_L));
            c.green = 16'(ramp_level(p, q, h));
            c.blue  = 16'(ramp_level(p, q, h - THIRD_L));
        end
        return c;
    endfunction

    function automatic logic [15:0] random_fraction();
        logic [15:0] corners[14];
        corners = '{16'd0, 16'd1, hsl2rgb_pkg::SIXTH - 16'd1, hsl2rgb_pkg::SIXTH,
                    hsl2rgb_pkg::THIRD, hsl2rgb_pkg::HALF - 16'd1, hsl2rgb_pkg::HALF,
                    hsl2rgb_pkg::TWO_THIRDS - 16'd1, hsl2rgb_pkg::TWO_THIRDS,
                    hsl2rgb_pkg::ONE - hsl2rgb_pkg::THIRD, hsl2rgb_pkg::ONE - 16'd1,
                    hsl2rgb_pkg::ONE, hsl2rgb_pkg::ONE + 16'd1, 16'hFFFF};
        case ($urandom_range(0, 9))
            6, 7:    return 16'($urandom);
            8, 9:    return corners[$urandom_range(0, 13)];
            default: return 16'($urandom_range(0, int'(hsl2rgb_pkg::ONE)));
        endcase
    endfunction

    task automatic add_pixel(logic [15:0] h, logic [15:0] s, logic [15:0] l);
        hsl_t px;
        px.hue        = h;
        px.saturation = s;
        px.lightness  = l;
        hsl_pending = {hsl_pending, px};
    endtask

    task automatic report_mismatch(string what);
        err_count++;
        $display("ERROR %0t: %s", $time, what);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: idle rate follows the phase, and the stream drains twice on the way
    always @(posedge clk or negedge rst_n)
    begin
        int  src_idle;
        bit  drain;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            n_launched    <= 0;
            n_accepted    <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                rgb_expected[n_accepted] = predict_rgb(hsl_t'(s_axis_tdata));
                n_accepted <= n_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                src_idle = (n_launched < n_pixels / 3) ? 35 :
                           (n_launched < 2 * n_pixels / 3) ? 56 : 0;
                drain = (n_launched == drain_at_a || n_launched == drain_at_b) &&
                        (s_axis_tvalid || n_accepted != n_checked);
                if (hsl_pending.size() != 0 && !drain &&
                    $urandom_range(0, 99) >= src_idle)
                begin
                    s_axis_tdata  <= hsl_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    n_launched    <= n_launched + 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t got;
        rgb_t want;
        int   snk_idle;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            n_checked     <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = rgb_t'(m_axis_tdata);
                if (n_checked >= n_accepted)
                    report_mismatch($sformatf("word %h with no pixel pending", got));
                else
                begin
                    want = rgb_expected[n_checked];
                    rgb_expected.delete(n_checked);
                    if (got.red !== want.red)
                        report_mismatch($sformatf("pixel %0d red %h, want %h",
                                                  n_checked, got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("pixel %0d green %h, want %h",
                                                  n_checked, got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("pixel %0d blue %h, want %h",
                                                  n_checked, got.blue, want.blue));
                    n_checked <= n_checked + 1;
                end
            end
            snk_idle = (n_checked < n_pixels / 3) ? 56 :
                       (n_checked < 2 * n_pixels / 3) ? 35 : 0;
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle);
        end
    end

    initial
    begin
        logic [15:0] s;
        rst_n     = 1'b0;
        err_count = 0;

        // extremes, codes above one and zero saturation
        add_pixel(16'd0, 16'd0, 16'd0);
        add_pixel(hsl2rgb_pkg::ONE, hsl2rgb_pkg::ONE, hsl2rgb_pkg::ONE);
        add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_pixel(16'd0, 16'd0, hsl2rgb_pkg::HALF);
        add_pixel(16'd12345, 16'd0, 16'hFFFF);
        add_pixel(hsl2rgb_pkg::ONE + 16'd1, 16'h8001, 16'h8001);
        // ramp argument landing exactly on one, for red and for green
        add_pixel(hsl2rgb_pkg::ONE - hsl2rgb_pkg::THIRD, hsl2rgb_pkg::ONE, hsl2rgb_pkg::HALF);
        add_pixel(hsl2rgb_pkg::ONE, hsl2rgb_pkg::ONE, hsl2rgb_pkg::HALF - 16'd1);
        // hue on both sides of each region boundary
        add_pixel(hsl2rgb_pkg::SIXTH - 16'd1, hsl2rgb_pkg::ONE, hsl2rgb_pkg::HALF);
        add_pixel(hsl2rgb_pkg::SIXTH, hsl2rgb_pkg::HALF, hsl2rgb_pkg::HALF);
        add_pixel(hsl2rgb_pkg::HALF - 16'd1, 16'd20000, 16'd10000);
        add_pixel(hsl2rgb_pkg::HALF, 16'd20000, 16'd10000);
        add_pixel(hsl2rgb_pkg::TWO_THIRDS - 16'd1, 16'd20000, 16'd30000);
        add_pixel(hsl2rgb_pkg::TWO_THIRDS, 16'd20000, 16'd30000);
        add_pixel(hsl2rgb_pkg::THIRD, 16'd1, 16'd1);
        add_pixel(16'd0, hsl2rgb_pkg::ONE, hsl2rgb_pkg::HALF);
        add_pixel(16'hAAAA, 16'h5555, 16'h2AAA);
        add_pixel(16'h5555, 16'h2AAA, 16'h4000);
        add_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF);
        drain_at_a = hsl_pending.size();

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            s = ($urandom_range(0, 9) == 0) ? 16'd0 : random_fraction();
            add_pixel(random_fraction(), s, random_fraction());
        end
        n_pixels   = hsl_pending.size();
        drain_at_b = n_pixels / 2;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (hsl_pending.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (n_checked != n_accepted)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_checked != n_accepted)
            report_mismatch($sformatf("%0d pixels never came out", n_accepted - n_checked));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/core/hsl2rgb_pkg.sv
rtl/core/hsl2rgb_channel.sv
rtl/core/hsl_to_rgb_converter.sv
tb/tb_hsl_to_rgb_converter.sv
